// ===== src/http_request_head_tokenizer_assert.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the request head tokenizer
// ---------------------------------------------------------------------------
`ifndef HTTP_REQUEST_HEAD_TOKENIZER_ASSERT_SVH
`define HTTP_REQUEST_HEAD_TOKENIZER_ASSERT_SVH

// check on every clock edge outside reset
`define HRHT_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// check on every clock edge, reset included
`define HRHT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/hrht_pkg.sv =====
// ---------------------------------------------------------------------------
// hrht_pkg
// Shared types and codes for the request head tokenizer.
// ---------------------------------------------------------------------------
`default_nettype none

package hrht_pkg;

  localparam int unsigned COUNT_BITS = 12;
  localparam int unsigned LIM_W      = 12;
  localparam int unsigned SHORT_W    = 8;
  localparam int unsigned CMP_W      = (COUNT_BITS > LIM_W) ? COUNT_BITS : LIM_W;

  // parse phases
  localparam logic [3:0] PH_METHOD = 4'd0;
  localparam logic [3:0] PH_URL    = 4'd1;
  localparam logic [3:0] PH_PROTO  = 4'd2;
  localparam logic [3:0] PH_HSTART = 4'd3;
  localparam logic [3:0] PH_NAME   = 4'd4;
  localparam logic [3:0] PH_VALUE  = 4'd5;
  localparam logic [3:0] PH_ENDCR  = 4'd6;
  localparam logic [3:0] PH_DONE   = 4'd7;
  localparam logic [3:0] PH_ERROR  = 4'd8;

  // sections
  localparam logic [2:0] SEC_METHOD = 3'd0;
  localparam logic [2:0] SEC_URL    = 3'd1;
  localparam logic [2:0] SEC_PROTO  = 3'd2;
  localparam logic [2:0] SEC_NAME   = 3'd3;
  localparam logic [2:0] SEC_VALUE  = 3'd4;

  // status
  localparam logic [1:0] ST_BUSY  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;
  localparam logic [1:0] ST_IDLE  = 2'd3;

  // characters
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PCT   = 8'h25;

  // register indexes
  localparam logic [1:0] REG_METHOD = 2'd0;
  localparam logic [1:0] REG_URL    = 2'd1;
  localparam logic [1:0] REG_PROTO  = 2'd2;
  localparam logic [1:0] REG_HEADER = 2'd3;

  localparam logic [SHORT_W-1:0] METHOD_LIMIT_RST = SHORT_W'(100);
  localparam logic [LIM_W-1:0]   URL_LIMIT_RST    = LIM_W'(1000);
  localparam logic [SHORT_W-1:0] PROTO_LIMIT_RST  = SHORT_W'(50);
  localparam logic [LIM_W-1:0]   HEADER_LIMIT_RST = LIM_W'(1000);

  typedef struct packed {
    logic [SHORT_W-1:0] method;
    logic [LIM_W-1:0]   url;
    logic [SHORT_W-1:0] proto;
    logic [LIM_W-1:0]   header;
  } limits_t;

  typedef struct packed {
    logic [3:0]            phase;
    logic [COUNT_BITS-1:0] count;
    logic                  cr_pending;
    logic [1:0]            esc_step;
    logic [3:0]            esc_high;
    logic                  esc_bad;
  } parse_t;

  typedef struct packed {
    logic       escape_error;
    logic [1:0] status;
    logic       field_end;
    logic [2:0] section;
    logic       byte_valid;
    logic [7:0] byte_out;
  } result_t;

  localparam parse_t PARSE_RST = '{
    phase: PH_METHOD, count: '0, cr_pending: 1'b0,
    esc_step: 2'd0, esc_high: 4'd0, esc_bad: 1'b0
  };

  // {bad, value}; a non-hex digit reads as zero
  function automatic logic [4:0] hex_digit(input logic [7:0] b);
    logic [4:0] r;
    r = 5'h10;
    if (b >= 8'h30 && b <= 8'h39) begin
      r = {1'b0, 4'(b - 8'h30)};
    end else if (b >= 8'h41 && b <= 8'h46) begin
      r = {1'b0, 4'(b - 8'h37)};
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/hrht_step.sv =====
// ---------------------------------------------------------------------------
// hrht_step
// Next parse state and result for one request byte.
// ---------------------------------------------------------------------------
`default_nettype none

module hrht_step
  import hrht_pkg::*;
(
  input  var parse_t     st_i,
  input  var limits_t    lim_i,
  input  wire [7:0]      byte_i,
  input  wire            first_i,
  output parse_t         st_o,
  output result_t        res_o
);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  parse_t                cur;
  parse_t                nxt;
  result_t               res;
  logic                  err;
  logic [COUNT_BITS-1:0] cnt;
  logic [CMP_W-1:0]      lim;
  logic                  room;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [4:0]            hd;

  always_comb begin
    cur = first_i ? PARSE_RST : st_i;
    cnt = (cur.phase == PH_HSTART) ? '0 : cur.count;
    unique case (cur.phase)
      PH_METHOD: lim = CMP_W'(lim_i.method);
      PH_URL:    lim = CMP_W'(lim_i.url);
      PH_PROTO:  lim = CMP_W'(lim_i.proto);
      default:   lim = CMP_W'(lim_i.header);
    endcase
    room    = CMP_W'(cnt) < lim;
    cnt_inc = (cnt == COUNT_MAX) ? cnt : cnt + 1'b1;
    hd      = hex_digit(byte_i);
  end

  always_comb begin
    nxt = cur;
    res = '0;
    err = 1'b0;
    unique case (cur.phase)
      PH_METHOD: begin
        res.section = SEC_METHOD;
        if (byte_i == CH_SP) begin
          res.field_end = 1'b1;
          nxt.phase     = PH_URL;
          nxt.count     = '0;
        end else if (!room) begin
          err = 1'b1;
        end else begin
          nxt.count      = cnt_inc;
          res.byte_out   = byte_i;
          res.byte_valid = 1'b1;
        end
      end
      PH_URL: begin
        res.section = SEC_URL;
        if (byte_i == CH_SP) begin
          if (cur.esc_step != 2'd0) begin
            res.byte_out     = {(cur.esc_step == 2'd2) ? cur.esc_high : 4'd0, 4'd0};
            res.byte_valid   = 1'b1;
            res.escape_error = 1'b1;
          end
          nxt.esc_step   = 2'd0;
          nxt.esc_high   = 4'd0;
          nxt.esc_bad    = 1'b0;
          res.field_end  = 1'b1;
          nxt.phase      = PH_PROTO;
          nxt.count      = '0;
          nxt.cr_pending = 1'b0;
        end else if (!room) begin
          err = 1'b1;
        end else begin
          nxt.count = cnt_inc;
          if (cur.esc_step == 2'd0) begin
            if (byte_i == CH_PCT) begin
              nxt.esc_step = 2'd1;
              nxt.esc_high = 4'd0;
              nxt.esc_bad  = 1'b0;
            end else begin
              res.byte_out   = byte_i;
              res.byte_valid = 1'b1;
            end
          end else if (cur.esc_step == 2'd1) begin
            nxt.esc_high = hd[3:0];
            nxt.esc_bad  = hd[4];
            nxt.esc_step = 2'd2;
          end else begin
            res.byte_out     = {cur.esc_high, hd[3:0]};
            res.byte_valid   = 1'b1;
            res.escape_error = cur.esc_bad | hd[4];
            nxt.esc_step     = 2'd0;
            nxt.esc_high     = 4'd0;
            nxt.esc_bad      = 1'b0;
          end
        end
      end
      PH_PROTO, PH_VALUE: begin
        res.section = (cur.phase == PH_PROTO) ? SEC_PROTO : SEC_VALUE;
        if (byte_i == CH_CR) begin
          nxt.cr_pending = 1'b1;
        end else if (byte_i == CH_LF && cur.cr_pending) begin
          nxt.cr_pending = 1'b0;
          res.field_end  = 1'b1;
          nxt.phase      = PH_HSTART;
          nxt.count      = '0;
        end else begin
          nxt.cr_pending = 1'b0;
          if (!room) begin
            err = 1'b1;
          end else begin
            nxt.count      = cnt_inc;
            res.byte_out   = byte_i;
            res.byte_valid = 1'b1;
          end
        end
      end
      PH_HSTART, PH_NAME: begin
        res.section = SEC_NAME;
        if (cur.phase == PH_HSTART && byte_i == CH_CR) begin
          nxt.phase = PH_ENDCR;
        end else if (cur.phase == PH_HSTART && byte_i == CH_SP) begin
          nxt.phase = PH_NAME;
          nxt.count = '0;
        end else begin
          nxt.phase = PH_NAME;
          nxt.count = cnt;
          if (byte_i == CH_COLON) begin
            res.field_end  = 1'b1;
            nxt.phase      = PH_VALUE;
            nxt.count      = '0;
            nxt.cr_pending = 1'b0;
          end else if (!room) begin
            err = 1'b1;
          end else begin
            nxt.count      = cnt_inc;
            res.byte_out   = byte_i;
            res.byte_valid = 1'b1;
          end
        end
      end
      PH_ENDCR: begin
        res.section = SEC_NAME;
        if (byte_i == CH_LF) begin
          res.status = ST_DONE;
          nxt.phase  = PH_DONE;
        end else begin
          err = 1'b1;
        end
      end
      PH_DONE: begin
        res.status = ST_IDLE;
      end
      default: begin
        res.status = ST_ERROR;
        nxt.phase  = PH_ERROR;
      end
    endcase

    if (err) begin
      nxt.phase        = PH_ERROR;
      nxt.esc_step     = 2'd0;
      nxt.esc_high     = 4'd0;
      nxt.esc_bad      = 1'b0;
      res.byte_out     = 8'd0;
      res.byte_valid   = 1'b0;
      res.field_end    = 1'b0;
      res.escape_error = 1'b0;
      res.status       = ST_ERROR;
    end
  end

  assign st_o  = nxt;
  assign res_o = res;

endmodule

`default_nettype wire

// ===== src/http_request_head_tokenizer.sv =====
// ---------------------------------------------------------------------------
// http_request_head_tokenizer
// Byte-wise HTTP/1.1 request head tokenizer with inline URL unescaping.
// ---------------------------------------------------------------------------
// Takes one request byte per item and gives one tagged result per item. The
// block sustains one item per clock while m_axis_tready stays high: a byte
// passes an input register, the parse state machine and the result register,
// and the input keeps flowing while a result waits on m_axis_tready, stalling
// only when both registers are full. Length limits are written over the APB
// port by the user only while no item is in flight; the block does not enforce this.
`default_nettype none

module http_request_head_tokenizer
  import hrht_pkg::*;
(
  input  wire         clk_i,
  input  wire         rst_ni,
  // configuration
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire  [3:0]  paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // request bytes
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [7:0]  s_axis_tdata,   // [7:0] byte_in
  input  wire  [0:0]  s_axis_tuser,   // [0] first_byte
  // tagged results
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] byte_out
  output logic [7:0]  m_axis_tuser    // [0] byte_valid, [3:1] section,
                                      // [4] field_end, [6:5] status,
                                      // [7] escape_error
);

  limits_t    lim_q;
  logic       cfg_wr;
  logic [1:0] reg_idx;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_first_q;
  logic       out_valid_q;
  result_t    out_q;
  parse_t     st_q;
  parse_t     st_d;
  result_t    res_d;
  logic       advance;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q.method <= METHOD_LIMIT_RST;
      lim_q.url    <= URL_LIMIT_RST;
      lim_q.proto  <= PROTO_LIMIT_RST;
      lim_q.header <= HEADER_LIMIT_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_METHOD: lim_q.method <= pwdata[SHORT_W-1:0];
        REG_URL:    lim_q.url    <= pwdata[LIM_W-1:0];
        REG_PROTO:  lim_q.proto  <= pwdata[SHORT_W-1:0];
        REG_HEADER: lim_q.header <= pwdata[LIM_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_METHOD: prdata = 32'(lim_q.method);
      REG_URL:    prdata = 32'(lim_q.url);
      REG_PROTO:  prdata = 32'(lim_q.proto);
      REG_HEADER: prdata = 32'(lim_q.header);
    endcase
  end

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_byte_q  <= s_axis_tdata;
      in_first_q <= s_axis_tuser[0];
    end
  end

  hrht_step u_step (
    .st_i    (st_q),
    .lim_i   (lim_q),
    .byte_i  (in_byte_q),
    .first_i (in_first_q),
    .st_o    (st_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= PARSE_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) begin
        st_q <= st_d;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q.byte_out;
  assign m_axis_tuser  = {out_q.escape_error, out_q.status, out_q.field_end,
                          out_q.section, out_q.byte_valid};

endmodule

`default_nettype wire

// ===== src/hrht_checker.sv =====
// ---------------------------------------------------------------------------
// hrht_checker
// Port-level checks on the tokenizer result stream.
// ---------------------------------------------------------------------------
`default_nettype none

`include "http_request_head_tokenizer_assert.svh"

module hrht_checker
  import hrht_pkg::*;
(
  input wire       clk_i,
  input wire       rst_ni,
  input wire       m_axis_tvalid,
  input wire       m_axis_tready,
  input wire [7:0] m_axis_tdata,
  input wire [7:0] m_axis_tuser
);

  logic       bv;
  logic [2:0] sec;
  logic [1:0] sts;
  logic       ee;

  assign bv  = m_axis_tuser[0];
  assign sec = m_axis_tuser[3:1];
  assign sts = m_axis_tuser[6:5];
  assign ee  = m_axis_tuser[7];

  `HRHT_ASSERT_ALWAYS(a_no_item_in_reset, clk_i, !rst_ni |=> !m_axis_tvalid, "item in reset")

  `HRHT_ASSERT(a_content_busy, clk_i, rst_ni, m_axis_tvalid && bv |-> sts == ST_BUSY, "content byte outside busy status")

  `HRHT_ASSERT(a_empty_zero, clk_i, rst_ni, m_axis_tvalid && !bv |-> m_axis_tdata == 8'd0, "non-content item carries data")

  `HRHT_ASSERT(a_escape_url, clk_i, rst_ni, m_axis_tvalid && ee |-> bv && sec == SEC_URL, "escape flag off a decoded URL byte")

  `HRHT_ASSERT(a_hold_stall, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled item changed")

endmodule

bind http_request_head_tokenizer hrht_checker u_hrht_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// ===== tb/sv/http_request_head_tokenizer_test.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// http_request_head_tokenizer_test
// Self-checking bench for the request head tokenizer.
// ---------------------------------------------------------------------------
// A queue of request bytes feeds the slave stream and a tokenizer model
// predicts the tagged result of every byte that is taken. Results on the
// master stream are checked field by field, in order. A short directed run
// hits escapes, lone CR, leading space, blank line, limits and the states
// after completion and error; random requests, broken requests and noise follow
// under several limit settings, with random gaps on both streams in all but one.
// ---------------------------------------------------------------------------

module http_request_head_tokenizer_test;
  import hrht_pkg::*;

  typedef struct packed {
    logic       start;
    logic [7:0] value;
  } req_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  wire  [31:0] prdata;
  wire         pready;
  logic        s_axis_tvalid = 1'b0;
  wire         s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  wire         m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  wire  [7:0]  m_axis_tdata;
  wire  [7:0]  m_axis_tuser;

  req_byte_t request_bytes[$];
  result_t   expected_tokens[$];
  limits_t   lim;
  parse_t    tok_state;
  result_t   seen;
  result_t   want;
  result_t   predicted;
  logic      item_taken = 1'b0;
  logic      steady = 1'b0;
  logic      next_first = 1'b0;
  int        noise_pct = 0;
  int        items_made = 0;
  int        mismatches = 0;

  http_request_head_tokenizer u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #6 clk_i = ~clk_i;

  function automatic logic [3:0] nibble_of(input logic [7:0] c, inout logic bad);
    if (c >= "0" && c <= "9") begin
      return 4'(c - "0");
    end
    if (c >= "A" && c <= "F") begin
      return 4'(c - "A" + 8'd10);
    end
    bad = 1'b1;
    return 4'h0;
  endfunction

  function automatic logic count_byte(input logic [CMP_W-1:0] limit);
    if (CMP_W'(tok_state.count) >= limit) begin
      return 1'b0;
    end
    if (tok_state.count != '1) begin
      tok_state.count = tok_state.count + 1'b1;
    end
    return 1'b1;
  endfunction

  function automatic result_t tokenize_byte(input logic [7:0] b, input logic restart);
    result_t r;
    logic    err;
    logic    bad;
    logic [3:0] lo;
    r = '0;
    err = 1'b0;
    bad = 1'b0;
    if (restart) begin
      tok_state = PARSE_RST;
    end
    case (tok_state.phase)
      PH_METHOD: begin
        r.section = SEC_METHOD;
        if (b == CH_SP) begin
          r.field_end = 1'b1;
          tok_state.phase = PH_URL;
          tok_state.count = '0;
        end else if (!count_byte(CMP_W'(lim.method))) begin
          err = 1'b1;
        end else begin
          r.byte_out = b;
          r.byte_valid = 1'b1;
        end
      end
      PH_URL: begin
        r.section = SEC_URL;
        if (b == CH_SP) begin
          if (tok_state.esc_step != 2'd0) begin
            r.byte_out = (tok_state.esc_step == 2'd2) ? {tok_state.esc_high, 4'h0} : 8'h00;
            r.byte_valid = 1'b1;
            r.escape_error = 1'b1;
          end
          tok_state.esc_step = 2'd0;
          tok_state.esc_high = 4'h0;
          tok_state.esc_bad = 1'b0;
          r.field_end = 1'b1;
          tok_state.phase = PH_PROTO;
          tok_state.count = '0;
          tok_state.cr_pending = 1'b0;
        end else if (!count_byte(CMP_W'(lim.url))) begin
          err = 1'b1;
        end else if (tok_state.esc_step == 2'd0) begin
          if (b == CH_PCT) begin
            tok_state.esc_step = 2'd1;
            tok_state.esc_high = 4'h0;
            tok_state.esc_bad = 1'b0;
          end else begin
            r.byte_out = b;
            r.byte_valid = 1'b1;
          end
        end else if (tok_state.esc_step == 2'd1) begin
          tok_state.esc_high = nibble_of(b, bad);
          tok_state.esc_bad = bad;
          tok_state.esc_step = 2'd2;
        end else begin
          bad = tok_state.esc_bad;
          lo = nibble_of(b, bad);
          r.byte_out = {tok_state.esc_high, lo};
          r.byte_valid = 1'b1;
          r.escape_error = bad;
          tok_state.esc_step = 2'd0;
          tok_state.esc_high = 4'h0;
          tok_state.esc_bad = 1'b0;
        end
      end
      PH_PROTO, PH_VALUE: begin
        r.section = (tok_state.phase == PH_PROTO) ? SEC_PROTO : SEC_VALUE;
        if (b == CH_CR) begin
          tok_state.cr_pending = 1'b1;
        end else if (b == CH_LF && tok_state.cr_pending) begin
          tok_state.cr_pending = 1'b0;
          r.field_end = 1'b1;
          tok_state.phase = PH_HSTART;
          tok_state.count = '0;
        end else begin
          tok_state.cr_pending = 1'b0;
          if (!count_byte((tok_state.phase == PH_PROTO) ? CMP_W'(lim.proto)
                                                         : CMP_W'(lim.header))) begin
            err = 1'b1;
          end else begin
            r.byte_out = b;
            r.byte_valid = 1'b1;
          end
        end
      end
      PH_HSTART, PH_NAME: begin
        r.section = SEC_NAME;
        if (tok_state.phase == PH_HSTART && b == CH_CR) begin
          tok_state.phase = PH_ENDCR;
        end else if (tok_state.phase == PH_HSTART && b == CH_SP) begin
          tok_state.phase = PH_NAME;
          tok_state.count = '0;
        end else begin
          if (tok_state.phase == PH_HSTART) begin
            tok_state.phase = PH_NAME;
            tok_state.count = '0;
          end
          if (b == CH_COLON) begin
            r.field_end = 1'b1;
            tok_state.phase = PH_VALUE;
            tok_state.count = '0;
            tok_state.cr_pending = 1'b0;
          end else if (!count_byte(CMP_W'(lim.header))) begin
            err = 1'b1;
          end else begin
            r.byte_out = b;
            r.byte_valid = 1'b1;
          end
        end
      end
      PH_ENDCR: begin
        r.section = SEC_NAME;
        if (b == CH_LF) begin
          r.status = ST_DONE;
          tok_state.phase = PH_DONE;
        end else begin
          err = 1'b1;
        end
      end
      PH_DONE: begin
        r.status = ST_IDLE;
      end
      default: begin
        r.status = ST_ERROR;
        tok_state.phase = PH_ERROR;
      end
    endcase
    if (err) begin
      tok_state.phase = PH_ERROR;
      tok_state.esc_step = 2'd0;
      tok_state.esc_high = 4'h0;
      tok_state.esc_bad = 1'b0;
      r.byte_out = 8'h00;
      r.byte_valid = 1'b0;
      r.field_end = 1'b0;
      r.escape_error = 1'b0;
      r.status = ST_ERROR;
    end
    return r;
  endfunction

  task automatic check_field(input string what, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predicted = tokenize_byte(s_axis_tdata, s_axis_tuser[0]);
        expected_tokens = {expected_tokens, predicted};
        void'(request_bytes.pop_front());
        item_taken = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        seen = result_t'({m_axis_tuser, m_axis_tdata});
        if (expected_tokens.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %0h", $time, seen);
          mismatches++;
        end else begin
          want = expected_tokens.pop_front();
          check_field("byte_out", want.byte_out, seen.byte_out);
          check_field("byte_valid", want.byte_valid, seen.byte_valid);
          check_field("section", want.section, seen.section);
          check_field("field_end", want.field_end, seen.field_end);
          check_field("status", want.status, seen.status);
          check_field("escape_error", want.escape_error, seen.escape_error);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || item_taken) begin
        if (request_bytes.size() != 0 && (steady || $urandom_range(99) >= 36)) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= request_bytes[0].value;
          s_axis_tuser <= request_bytes[0].start;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= steady || ($urandom_range(99) >= 36);
    end
    item_taken = 1'b0;
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_limits(input int unsigned m, input int unsigned u,
                            input int unsigned p, input int unsigned h);
    write_reg(REG_METHOD, m);
    write_reg(REG_URL, u);
    write_reg(REG_PROTO, p);
    write_reg(REG_HEADER, h);
    lim = '{method: SHORT_W'(m), url: LIM_W'(u), proto: SHORT_W'(p), header: LIM_W'(h)};
  endtask

  task automatic drain();
    while (request_bytes.size() != 0 || expected_tokens.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic put(input logic [7:0] b);
    req_byte_t rb;
    if (noise_pct != 0 && $urandom_range(99) < noise_pct) begin
      rb.start = 1'b0;
      rb.value = 8'($urandom_range(255));
      request_bytes = {request_bytes, rb};
    end
    rb.start = next_first;
    rb.value = b;
    request_bytes = {request_bytes, rb};
    next_first = 1'b0;
    items_made++;
  endtask

  task automatic put_all(input logic [7:0] seq[$]);
    next_first = 1'b1;
    foreach (seq[i]) begin
      put(seq[i]);
    end
  endtask

  function automatic logic [7:0] rand_char(input logic [7:0] a, input logic [7:0] b,
                                           input logic [7:0] c);
    logic [7:0] ch;
    do begin
      if ($urandom_range(3) == 0) begin
        ch = 8'($urandom_range(255));
      end else begin
        ch = 8'($urandom_range(8'h21, 8'h7E));
      end
    end while (ch == a || ch == b || ch == c);
    return ch;
  endfunction

  function automatic logic [7:0] hex_char();
    int unsigned v;
    if ($urandom_range(7) == 0) begin
      return rand_char(CH_SP, CH_SP, CH_SP);
    end
    v = $urandom_range(15);
    return (v < 10) ? 8'("0" + v) : 8'("A" + v - 10);
  endfunction

  function automatic int field_len();
    return ($urandom_range(9) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 8);
  endfunction

  task automatic put_line_text(input int n);
    repeat (n) begin
      if ($urandom_range(7) == 0) begin
        put(CH_CR);
        put(rand_char(CH_LF, CH_CR, CH_CR));
      end else begin
        put(rand_char(CH_CR, CH_CR, CH_CR));
      end
    end
    put(CH_CR);
    put(CH_LF);
  endtask

  task automatic put_request();
    int n;
    logic spaced;
    next_first = 1'b1;
    repeat (field_len()) put(rand_char(CH_SP, CH_SP, CH_SP));
    put(CH_SP);
    n = field_len();
    for (int k = 0; k < n; k++) begin
      case ($urandom_range(9))
        0, 1: begin
          put(CH_PCT);
          put(hex_char());
          put(hex_char());
        end
        2: begin
          put(CH_PCT);
          if ($urandom_range(1) == 1) begin
            put(hex_char());
          end
          k = n;
        end
        default: put(rand_char(CH_SP, CH_SP, CH_SP));
      endcase
    end
    put(CH_SP);
    put_line_text(field_len());
    repeat ($urandom_range(3)) begin
      spaced = ($urandom_range(2) == 0);
      if (spaced) begin
        put(CH_SP);
      end
      n = field_len();
      for (int k = 0; k < n; k++) begin
        put((k == 0 && !spaced) ? rand_char(CH_COLON, CH_CR, CH_SP)
                                : rand_char(CH_COLON, CH_CR, CH_CR));
      end
      put(CH_COLON);
      put_line_text(field_len());
    end
    put(CH_CR);
    put(($urandom_range(15) == 0) ? rand_char(CH_LF, CH_LF, CH_LF) : CH_LF);
    repeat (($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0) begin
      put(8'($urandom_range(255)));
    end
  endtask

  task automatic put_noise();
    repeat ($urandom_range(1, 6)) begin
      next_first = ($urandom_range(3) == 0);
      put(8'($urandom_range(255)));
    end
  endtask

  task automatic put_random(input int count);
    int goal;
    goal = items_made + count;
    while (items_made < goal) begin
      case ($urandom_range(9))
        7, 8: begin
          noise_pct = 6;
          put_request();
          noise_pct = 0;
        end
        9: put_noise();
        default: put_request();
      endcase
    end
  endtask

  initial begin
    lim = '{method: METHOD_LIMIT_RST, url: URL_LIMIT_RST,
            proto: PROTO_LIMIT_RST, header: HEADER_LIMIT_RST};
    tok_state = PARSE_RST;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    put_all('{CH_SP, CH_PCT, "4", "g", CH_PCT, "4", CH_SP, "P", CH_CR, "x", CH_CR, CH_LF,
              CH_SP, "A", CH_COLON, 8'h00, CH_CR, CH_LF, CH_CR, CH_LF, 8'hFF});
    drain();

    set_limits(1, 1, 1, 1);
    put_all('{"A", "B"});
    put_all('{CH_SP, CH_SP, CH_CR, CH_LF, CH_CR, "Y", "Z"});
    put_random(300);
    drain();

    set_limits(255, 4095, 255, 4095);
    steady = 1'b1;
    put_random(550);
    drain();
    steady = 1'b0;

    set_limits($urandom_range(1, 40), $urandom_range(1, 40),
               $urandom_range(1, 40), $urandom_range(1, 40));
    put_random(550);
    drain();

    set_limits($urandom_range(1, 255), $urandom_range(1, 4095),
               $urandom_range(1, 255), $urandom_range(1, 4095));
    put_random(550);
    drain();

    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== http_request_head_tokenizer.f =====
+incdir+src
src/hrht_pkg.sv
src/hrht_step.sv
src/http_request_head_tokenizer.sv
src/hrht_checker.sv
tb/sv/http_request_head_tokenizer_test.sv
